@@ rtl/assert_macros.svh @@
// Assertion macros for the key/value extractor.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define KVX_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error("kvx check failed");
`define KVX_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error("kvx check failed");
`endif

@@ rtl/kvx_pkg.sv @@
// Types, character codes and register indexes for the key/value extractor.
// No dependencies.
package kvx_pkg;
  localparam int unsigned KEY_BYTES = 8;
  localparam logic [7:0] MAX_NEST = 8'd255;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [1:0] CFG_KEY_TEXT  = 2'd0;
  localparam logic [1:0] CFG_KEY_LEN   = 2'd1;
  localparam logic [1:0] CFG_CAPACITY  = 2'd2;
  localparam logic [1:0] CFG_PRESENCE  = 2'd3;

  typedef enum logic [2:0] {
    PH_SEARCH, PH_QUOTE, PH_BLANK1, PH_BLANK2, PH_COPY, PH_DONE
  } phase_e;

  typedef struct packed {
    logic [KEY_BYTES-1:0][7:0] window;
    logic [3:0]                fill;
    phase_e                    phase;
    logic                      in_quotes;
    logic [7:0]                depth;
    logic                      esc;
    logic                      obj;
    logic                      quoted;
    logic [15:0]               room;
  } scan_t;

  typedef struct packed {
    logic [63:0] key_text;
    logic [3:0]  key_len;
    logic [15:0] capacity;
    logic        presence;
  } cfg_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       char_valid;
    logic       finished;
    logic       found;
  } res_t;

  localparam scan_t SCAN_RESET = '{window: '0, fill: 4'd0, phase: PH_SEARCH,
                                   in_quotes: 1'b0, depth: 8'd0, esc: 1'b0,
                                   obj: 1'b0, quoted: 1'b1, room: 16'd0};
endpackage

@@ rtl/kvx_step.sv @@
// Next-state and result logic for one text byte.
// Depends on kvx_pkg.
module kvx_step (
  input  kvx_pkg::scan_t st_i,
  input  kvx_pkg::cfg_t  cfg_i,
  input  logic [7:0]     byte_i,
  input  logic           eot_i,
  output kvx_pkg::scan_t st_o,
  output kvx_pkg::res_t  res0_o,
  output kvx_pkg::res_t  res1_o,
  output logic           push0_o,
  output logic           push1_o
);
  import kvx_pkg::*;

  logic [3:0]                len;
  logic [KEY_BYTES-1:0][7:0] w;
  logic [3:0]                f;
  logic                      same;
  logic [7:0]                hd;
  logic                      do_copy;
  logic                      cp;
  logic                      stp;
  logic                      closer;
  logic                      blank;
  res_t                      fin1;
  res_t                      fin0;

  assign len  = (cfg_i.key_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : cfg_i.key_len;
  assign fin1 = '{ch: 8'd0, char_valid: 1'b0, finished: 1'b1, found: 1'b1};
  assign fin0 = '{ch: 8'd0, char_valid: 1'b0, finished: 1'b1, found: 1'b0};
  assign blank = (byte_i == CH_SPACE) || (byte_i == CH_TAB);
  assign closer = (byte_i == CH_RBRACE) || (byte_i == CH_RBRACK);

  always_comb begin
    st_o    = st_i;
    res0_o  = '0;
    res1_o  = '0;
    push0_o = 1'b0;
    push1_o = 1'b0;
    w       = st_i.window;
    f       = st_i.fill;
    same    = 1'b1;
    hd      = 8'd0;
    do_copy = 1'b0;
    cp      = 1'b0;
    stp     = 1'b0;
    if (eot_i) begin
      if (st_i.phase != PH_DONE) begin
        res0_o  = fin0;
        push0_o = 1'b1;
      end
      st_o = SCAN_RESET;
    end else begin
      unique case (st_i.phase)
        PH_SEARCH: begin
          if (len != 4'd0) begin
            if (f < 4'(KEY_BYTES)) begin
              w[f[2:0]] = byte_i;
              f = f + 4'd1;
            end
            if (f >= len) begin
              hd = w[0];
              for (int i = 0; i < KEY_BYTES; i++) begin
                if ((4'(i) < len) && (w[i] != cfg_i.key_text[i*8 +: 8])) same = 1'b0;
              end
              if (!st_i.esc && same && (st_i.depth <= 8'd1)) begin
                w = '0;
                f = 4'd0;
                st_o.phase = PH_QUOTE;
              end else begin
                for (int i = 0; i < KEY_BYTES - 1; i++) w[i] = w[i+1];
                w[KEY_BYTES-1] = 8'd0;
                if (f != 4'd0) f = f - 4'd1;
                if (st_i.esc) begin
                  st_o.esc = 1'b0;
                end else if (!same) begin
                  if (hd == CH_QUOTE) begin
                    st_o.in_quotes = ~st_i.in_quotes;
                  end else if (hd == CH_BSLASH) begin
                    if (st_i.in_quotes) st_o.esc = 1'b1;
                  end else if (hd == CH_LBRACE || hd == CH_LBRACK) begin
                    if (!st_i.in_quotes && st_i.depth < MAX_NEST)
                      st_o.depth = st_i.depth + 8'd1;
                  end else if (hd == CH_RBRACE || hd == CH_RBRACK) begin
                    if (!st_i.in_quotes) begin
                      if (st_i.depth == 8'd0) begin
                        res0_o     = fin0;
                        push0_o    = 1'b1;
                        st_o.phase = PH_DONE;
                      end else begin
                        st_o.depth = st_i.depth - 8'd1;
                      end
                    end
                  end
                end
              end
            end
            st_o.window = w;
            st_o.fill   = f;
          end
        end
        PH_QUOTE: st_o.phase = (byte_i == CH_QUOTE) ? PH_BLANK1 : PH_SEARCH;
        PH_BLANK1: begin
          if (byte_i == CH_COLON) st_o.phase = PH_BLANK2;
          else if (!blank) st_o.phase = PH_SEARCH;
        end
        PH_BLANK2: begin
          if (!blank) begin
            if (cfg_i.presence) begin
              res0_o     = fin1;
              push0_o    = 1'b1;
              st_o.phase = PH_DONE;
            end else begin
              st_o.obj       = (byte_i == CH_LBRACE) || (byte_i == CH_LBRACK);
              st_o.quoted    = (byte_i == CH_QUOTE);
              st_o.in_quotes = !st_o.obj;
              st_o.depth     = 8'd0;
              st_o.esc       = 1'b0;
              st_o.room      = cfg_i.capacity;
              st_o.phase     = PH_COPY;
              if (!st_o.quoted) begin
                if (cfg_i.capacity <= 16'd1) begin
                  res0_o     = fin1;
                  push0_o    = 1'b1;
                  st_o.phase = PH_DONE;
                end else begin
                  do_copy = 1'b1;
                end
              end
            end
          end
        end
        PH_COPY: begin
          if (st_i.room <= 16'd1) begin
            res0_o     = fin1;
            push0_o    = 1'b1;
            st_o.phase = PH_DONE;
          end else begin
            do_copy = 1'b1;
          end
        end
        PH_DONE: ;
        default: ;
      endcase
      if (do_copy) begin
        cp = 1'b1;
        if (st_o.esc) begin
          st_o.esc = 1'b0;
        end else if (byte_i == CH_LBRACE || byte_i == CH_LBRACK) begin
          if (!st_o.in_quotes && st_o.depth < MAX_NEST) st_o.depth = st_o.depth + 8'd1;
        end else if (closer && !st_o.quoted && !st_o.in_quotes) begin
          if (st_o.depth != 8'd0) st_o.depth = st_o.depth - 8'd1;
          if (st_o.depth == 8'd0) begin
            cp  = st_o.obj;
            stp = 1'b1;
          end
        end else if (closer || byte_i == CH_QUOTE || byte_i == CH_COMMA) begin
          if (!(st_o.quoted && byte_i != CH_QUOTE)) begin
            if (byte_i == CH_QUOTE) st_o.in_quotes = ~st_o.in_quotes;
            if (!st_o.obj) begin
              cp  = 1'b0;
              stp = 1'b1;
            end
          end
        end else if (byte_i == CH_BSLASH) begin
          st_o.esc = 1'b1;
        end
        if (cp) begin
          res0_o    = '{ch: byte_i, char_valid: 1'b1, finished: 1'b0, found: 1'b0};
          push0_o   = 1'b1;
          st_o.room = st_o.room - 16'd1;
          if (stp) begin
            res1_o  = fin1;
            push1_o = 1'b1;
          end
        end else if (stp) begin
          res0_o  = fin1;
          push0_o = 1'b1;
        end
        if (stp) st_o.phase = PH_DONE;
      end
    end
  end
endmodule

@@ rtl/kvx_ofifo.sv @@
// Four-entry result queue taking up to two requests per cycle.
// Depends on kvx_pkg.
module kvx_ofifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push0_i,
  input  logic          push1_i,
  input  kvx_pkg::res_t res0_i,
  input  kvx_pkg::res_t res1_i,
  output logic          room2_o,
  output logic          valid_o,
  input  logic          ready_i,
  output kvx_pkg::res_t res_o
);
  import kvx_pkg::*;

  res_t       mem_q [4];
  logic [1:0] wptr_q, wptr_d;
  logic [1:0] rptr_q, rptr_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;
  logic [2:0] npush;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 3'd0);
  assign room2_o = (cnt_q <= 3'd2);
  assign res_o   = mem_q[rptr_q];
  assign npush   = {2'b00, push0_i} + {2'b00, push1_i};
  assign wptr_d  = wptr_q + npush[1:0];
  assign rptr_d  = rptr_q + {1'b0, pop};
  assign cnt_d   = cnt_q + npush - {2'b00, pop};

  always_ff @(posedge clk_i) begin
    if (push0_i) mem_q[wptr_q] <= res0_i;
    if (push1_i) mem_q[wptr_q + 2'd1] <= res1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 2'd0;
      rptr_q <= 2'd0;
      cnt_q  <= 3'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end
endmodule

@@ rtl/json_key_value_extractor_core.sv @@
// Results are written into the registered result queue when the byte that causes them is accepted.
// Throughput: one byte per cycle while the four-entry result queue has room
// for two requests; the step logic is combinational and sets this rate.
// Reset: asynchronous, active low; state returns to a fresh search, registers
// to their defaults (key length 1, capacity 64).
module json_key_value_extractor_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  value_char_o,
  output logic        char_valid_o,
  output logic        finished_o,
  output logic        key_found_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import kvx_pkg::*;
`include "assert_macros.svh"

  scan_t st_q, st_d;
  cfg_t  cfg_q;
  res_t  res0, res1, res_out;
  logic  push0, push1, room2, acc;

  assign in_ready_o  = room2;
  assign cfg_ready_o = 1'b1;
  assign acc         = in_valid_i && in_ready_o;

  kvx_step u_step (
    .st_i(st_q), .cfg_i(cfg_q), .byte_i(text_byte_i), .eot_i(end_of_text_i),
    .st_o(st_d), .res0_o(res0), .res1_o(res1), .push0_o(push0), .push1_o(push1)
  );

  kvx_ofifo u_ofifo (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push0_i(push0 && acc), .push1_i(push1 && acc),
    .res0_i(res0), .res1_i(res1), .room2_o(room2),
    .valid_o(out_valid_o), .ready_i(out_ready_i), .res_o(res_out)
  );

  assign value_char_o = res_out.ch;
  assign char_valid_o = res_out.char_valid;
  assign finished_o   = res_out.finished;
  assign key_found_o  = res_out.found;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= SCAN_RESET;
      cfg_q <= '{key_text: 64'd0, key_len: 4'd1, capacity: 16'd64, presence: 1'b0};
    end else begin
      if (acc) st_q <= st_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_KEY_TEXT: cfg_q.key_text <= cfg_data_i;
          CFG_KEY_LEN:  cfg_q.key_len  <= cfg_data_i[3:0];
          CFG_CAPACITY: cfg_q.capacity <= cfg_data_i[15:0];
          CFG_PRESENCE: cfg_q.presence <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  `KVX_ASSERT_NEXT(a_eot_restart, acc && end_of_text_i, st_q.phase == PH_SEARCH && st_q.fill == 4'd0)
  `KVX_ASSERT(a_fill_bound, st_q.fill <= 4'(KEY_BYTES))
  `KVX_ASSERT(a_quote_empty, st_q.phase != PH_QUOTE || st_q.fill == 4'd0)
  `KVX_ASSERT(a_pair_order, !(push1 && !push0))
endmodule
